// ===== hw/rtl/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types, command codes and filter coefficients for the product detector.
// ----------------------------------------------------------------------------
package spd_pkg;

  // APB address width: two 32-bit registers at byte offsets 0 and 4
  localparam int ADDR_W = 3;

  // accumulator width: three Q5.26 terms of up to 2^32 each plus the input
  localparam int ACC_W = 36;

  // pi/2 in Q2.30, for building the sine table
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // multiplier operand selects
  localparam logic [2:0] OP_MIX  = 3'd0;
  localparam logic [2:0] OP_A1Z1 = 3'd1;
  localparam logic [2:0] OP_A2Z2 = 3'd2;
  localparam logic [2:0] OP_B1Z1 = 3'd3;
  localparam logic [2:0] OP_B2Z2 = 3'd4;
  localparam logic [2:0] OP_B0W  = 3'd5;
  localparam logic [2:0] OP_OUT  = 3'd6;

  // accumulator actions on the registered product
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_LOAD  = 3'd1;
  localparam logic [2:0] ACT_SUB   = 3'd2;
  localparam logic [2:0] ACT_SUB_W = 3'd3;
  localparam logic [2:0] ACT_ADD   = 3'd4;
  localparam logic [2:0] ACT_Y     = 3'd5;
  localparam logic [2:0] ACT_RES   = 3'd6;

  // coefficient slots within one set
  localparam int C_B0 = 0;
  localparam int C_B1 = 1;
  localparam int C_B2 = 2;
  localparam int C_A1 = 3;
  localparam int C_A2 = 4;

  // output scale factor (2 * 32767)
  localparam logic signed [24:0] OUT_SCALE = 25'sd65534;

  typedef logic signed [24:0] coef_t;

  // Q2.22 biquad coefficients, section s uses set s mod 2
  localparam coef_t COEF [2][5] = '{
    '{25'sd413270,  25'sd826539,  25'sd413270,  -25'sd3954428, 25'sd1398101},
    '{25'sd4194304, 25'sd8388608, 25'sd4194304, -25'sd1123860, 25'sd719629}
  };

  typedef struct packed {
    logic       load;      // capture input item, clear on restart
    logic       osc_step;  // read cosine, advance phase
    logic [2:0] op;        // multiplier operand select
    logic [2:0] act;       // accumulator action
    logic       deliver;   // move result into output register
  } cmd_t;

endpackage

// ===== hw/rtl/spd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// spd_cfg_regs
// APB register file: enable bit and oscillator frequency, plus phase increment.
// ----------------------------------------------------------------------------
module spd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       enabled,
  output logic [31:0]                phase_inc
);
  import spd_pkg::*;

  localparam logic       REG_ENABLED = 1'b0;
  localparam logic       REG_BFO_HZ  = 1'b1;
  localparam logic [11:0] BFO_MIN    = 12'd100;
  localparam logic [11:0] BFO_MAX    = 12'd4000;
  localparam logic [11:0] BFO_RESET  = 12'd1500;

  // increment = floor(hz * 2^28 / 1000) = hz*268435 + floor(hz*57/125);
  // the fraction uses an exact reciprocal multiply for hz below 4096
  function automatic logic [31:0] inc_of(input logic [11:0] hz);
    logic [31:0] whole;
    logic [35:0] frac;
    whole = 32'(hz) * 32'd268435;
    frac  = 36'(hz) * 36'd7650426;
    return whole + 32'(frac >> 24);
  endfunction

  logic [11:0] bfo_hz;
  logic [11:0] bfo_next;
  logic        reg_idx;
  logic        wr;

  assign reg_idx = paddr[2];
  assign wr      = psel & penable & pwrite;

  always_comb begin
    if (pwdata[11:0] < BFO_MIN) begin
      bfo_next = BFO_MIN;
    end else if (pwdata[11:0] > BFO_MAX) begin
      bfo_next = BFO_MAX;
    end else begin
      bfo_next = pwdata[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled   <= 1'b0;
      bfo_hz    <= BFO_RESET;
      phase_inc <= inc_of(BFO_RESET);
    end else begin
      phase_inc <= inc_of(bfo_hz);
      if (wr) begin
        case (reg_idx)
          REG_ENABLED: enabled <= pwdata[0];
          REG_BFO_HZ:  bfo_hz  <= bfo_next;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLED: prdata = {31'd0, enabled};
      REG_BFO_HZ:  prdata = {20'd0, bfo_hz};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/spd_ctrl.sv =====
// ----------------------------------------------------------------------------
// spd_ctrl
// Sequencer: schedules the shared multiplier over mixer, biquads and output.
// ----------------------------------------------------------------------------
module spd_ctrl #(
  parameter int SECTIONS = 2,
  localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            enabled,
  input  logic            out_free,
  output spd_pkg::cmd_t   cmd,
  output logic [SW-1:0]   sec,
  output logic [SW-1:0]   upd
);
  import spd_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_OSC     = 3'd1;
  localparam logic [2:0] ST_MIX     = 3'd2;
  localparam logic [2:0] ST_SEC     = 3'd3;
  localparam logic [2:0] ST_YEND    = 3'd4;
  localparam logic [2:0] ST_OUTM    = 3'd5;
  localparam logic [2:0] ST_OUTC    = 3'd6;
  localparam logic [2:0] ST_DELIVER = 3'd7;

  localparam logic [2:0] STEP_A1 = 3'd0;
  localparam logic [2:0] STEP_A2 = 3'd1;
  localparam logic [2:0] STEP_B1 = 3'd2;
  localparam logic [2:0] STEP_B2 = 3'd3;
  localparam logic [2:0] STEP_B0 = 3'd4;

  localparam logic [SW-1:0] SEC_LAST = SW'(SECTIONS - 1);

  logic [2:0]    state, state_next;
  logic [2:0]    step, step_next;
  logic [SW-1:0] sec_cnt, sec_next;

  assign in_ready = (state == ST_IDLE);
  assign sec      = sec_cnt;
  assign upd      = (state == ST_SEC) ? sec_cnt - SW'(1) : SEC_LAST;

  always_comb begin
    state_next = state;
    step_next  = step;
    sec_next   = sec_cnt;
    cmd        = '0;
    cmd.op     = OP_MIX;
    cmd.act    = ACT_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = enabled ? ST_OSC : ST_DELIVER;
        end
      end
      ST_OSC: begin
        cmd.osc_step = 1'b1;
        state_next   = ST_MIX;
      end
      ST_MIX: begin
        cmd.op     = OP_MIX;
        state_next = ST_SEC;
        step_next  = STEP_A1;
        sec_next   = '0;
      end
      ST_SEC: begin
        case (step)
          STEP_A1: begin
            // first section loads the mixer output, later ones finish y
            cmd.op    = OP_A1Z1;
            cmd.act   = (sec_cnt == '0) ? ACT_LOAD : ACT_Y;
            step_next = STEP_A2;
          end
          STEP_A2: begin
            cmd.op    = OP_A2Z2;
            cmd.act   = ACT_SUB;
            step_next = STEP_B1;
          end
          STEP_B1: begin
            cmd.op    = OP_B1Z1;
            cmd.act   = ACT_SUB_W;
            step_next = STEP_B2;
          end
          STEP_B2: begin
            cmd.op    = OP_B2Z2;
            cmd.act   = ACT_ADD;
            step_next = STEP_B0;
          end
          STEP_B0: begin
            cmd.op    = OP_B0W;
            cmd.act   = ACT_ADD;
            step_next = STEP_A1;
            if (sec_cnt == SEC_LAST) begin
              state_next = ST_YEND;
            end else begin
              sec_next = sec_cnt + SW'(1);
            end
          end
          default: step_next = STEP_A1;
        endcase
      end
      ST_YEND: begin
        cmd.act    = ACT_Y;
        state_next = ST_OUTM;
      end
      ST_OUTM: begin
        cmd.op     = OP_OUT;
        state_next = ST_OUTC;
      end
      ST_OUTC: begin
        cmd.act    = ACT_RES;
        state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_free) begin
          cmd.deliver = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      step    <= STEP_A1;
      sec_cnt <= '0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      sec_cnt <= sec_next;
    end
  end

endmodule

// ===== hw/rtl/spd_datapath.sv =====
// ----------------------------------------------------------------------------
// spd_datapath
// Oscillator, sine table, shared multiplier, accumulator, delays, output stage.
// ----------------------------------------------------------------------------
module spd_datapath #(
  parameter int SINE_ENTRIES = 256,
  parameter int SECTIONS     = 2,
  localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [15:0] sample_in,
  input  logic               restart,
  input  logic [31:0]        phase_inc,
  input  spd_pkg::cmd_t      cmd,
  input  logic [SW-1:0]      sec,
  input  logic [SW-1:0]      upd,
  output logic               out_free,
  output logic signed [15:0] sample_out,
  output logic               out_valid,
  input  logic               out_ready
);
  import spd_pkg::*;

  localparam int IW      = $clog2(SINE_ENTRIES);
  localparam int NW      = $clog2(SINE_ENTRIES + 1);
  localparam int QUARTER = SINE_ENTRIES / 4;

  localparam logic signed [ACC_W-1:0] S32_MAX = 36'sh07FFFFFFF;
  localparam logic signed [ACC_W-1:0] S32_MIN = 36'shF80000000;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > S32_MAX) begin
      return 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // sine table, Q1.15, built at elaboration by a first-quadrant Taylor series
  logic signed [15:0] sine_tab [SINE_ENTRIES];

  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_sine
    localparam logic [63:0] NN  = 64'(SINE_ENTRIES);
    localparam logic [63:0] M0  = 64'(4 * k);
    localparam bit          NEG = (M0 >= 2 * NN);
    localparam logic [63:0] M1  = NEG ? M0 - 2 * NN : M0;
    localparam logic [63:0] MQ  = (M1 > NN) ? 2 * NN - M1 : M1;
    localparam logic [63:0] A   = (PI_HALF_Q30 * MQ) / SINE_ENTRIES;
    localparam logic [63:0] A2  = (A * A) >> 30;
    localparam logic [63:0] T1  = ((A * A2) >> 30) / 64'd6;
    localparam logic [63:0] T2  = ((T1 * A2) >> 30) / 64'd20;
    localparam logic [63:0] T3  = ((T2 * A2) >> 30) / 64'd42;
    localparam logic [63:0] T4  = ((T3 * A2) >> 30) / 64'd72;
    localparam logic [63:0] T5  = ((T4 * A2) >> 30) / 64'd110;
    localparam logic [63:0] T6  = ((T5 * A2) >> 30) / 64'd156;
    localparam logic [63:0] T7  = ((T6 * A2) >> 30) / 64'd210;
    localparam logic signed [63:0] S = $signed(A) - $signed(T1) + $signed(T2)
                                     - $signed(T3) + $signed(T4) - $signed(T5)
                                     + $signed(T6) - $signed(T7);
    localparam logic signed [63:0] SC = (S < 0) ? 64'sd0 : S;
    localparam logic signed [63:0] Q0 = (SC + 64'sd16384) >>> 15;
    localparam logic signed [63:0] QS = (Q0 > 64'sd32767) ? 64'sd32767 : Q0;
    localparam logic signed [63:0] E  = NEG ? -QS : QS;
    assign sine_tab[k] = E[15:0];
  end

  logic [31:0]        phase;
  logic [31+NW:0]     phase_scaled;
  logic [IW-1:0]      idx;
  logic [IW:0]        idx_sum;
  logic [IW-1:0]      cidx;
  logic signed [15:0] lo;
  logic signed [15:0] x_reg;
  logic signed [15:0] res;

  // table index = floor(phase * entries / 2^32), cosine a quarter turn ahead
  assign phase_scaled = {{NW{1'b0}}, phase} * {32'd0, NW'(SINE_ENTRIES)};
  assign idx          = phase_scaled[32+IW-1:32];
  assign idx_sum      = {1'b0, idx} + (IW+1)'(QUARTER);
  assign cidx         = (idx_sum >= (IW+1)'(SINE_ENTRIES))
                      ? IW'(idx_sum - (IW+1)'(SINE_ENTRIES)) : idx_sum[IW-1:0];

  logic signed [31:0]      mul_a;
  logic signed [24:0]      mul_b;
  logic signed [56:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prod_fs22;
  logic signed [ACC_W-1:0] prod_fs4;
  logic signed [ACC_W-1:0] acc_sub;
  logic signed [ACC_W-1:0] acc_add;
  logic signed [31:0]      w;
  logic signed [31:0]      z1 [SECTIONS];
  logic signed [31:0]      z2 [SECTIONS];
  logic                    cs;

  assign cs = sec[0];

  always_comb begin
    case (cmd.op)
      OP_MIX: begin
        mul_a = 32'(x_reg);
        mul_b = 25'(lo);
      end
      OP_A1Z1: begin
        mul_a = z1[sec];
        mul_b = COEF[cs][C_A1];
      end
      OP_A2Z2: begin
        mul_a = z2[sec];
        mul_b = COEF[cs][C_A2];
      end
      OP_B1Z1: begin
        mul_a = z1[sec];
        mul_b = COEF[cs][C_B1];
      end
      OP_B2Z2: begin
        mul_a = z2[sec];
        mul_b = COEF[cs][C_B2];
      end
      OP_B0W: begin
        mul_a = w;
        mul_b = COEF[cs][C_B0];
      end
      OP_OUT: begin
        mul_a = acc[31:0];
        mul_b = OUT_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_fs22 = ACC_W'(prod >>> 22);
  assign prod_fs4  = ACC_W'(prod >>> 4);
  assign acc_sub   = acc - prod_fs22;
  assign acc_add   = acc + prod_fs22;

  // output: truncate toward zero by 2^26, then saturate to 16 bits
  logic signed [56:0] prod_round;
  logic signed [56:0] q_full;
  logic signed [15:0] q_sat;

  assign prod_round = prod[56] ? prod + 57'sd67108863 : prod;
  assign q_full     = prod_round >>> 26;

  always_comb begin
    if (q_full > 57'sd32767) begin
      q_sat = 16'sh7FFF;
    end else if (q_full < -57'sd32768) begin
      q_sat = 16'sh8000;
    end else begin
      q_sat = q_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load) begin
      x_reg <= sample_in;
      res   <= sample_in;
    end
    if (cmd.osc_step) begin
      lo <= sine_tab[cidx];
    end
    case (cmd.act)
      ACT_LOAD:  acc <= prod_fs4;
      ACT_SUB:   acc <= acc_sub;
      ACT_SUB_W: begin
        w   <= sat32(acc_sub);
        acc <= '0;
      end
      ACT_ADD:   acc <= acc_add;
      ACT_Y:     acc <= ACC_W'(sat32(acc_add));
      ACT_RES:   res <= q_sat;
      default: ;
    endcase
  end

  // oscillator phase and filter delays: cleared by reset and by restart
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      for (int s = 0; s < SECTIONS; s++) begin
        z1[s] <= '0;
        z2[s] <= '0;
      end
    end else if (cmd.load && restart) begin
      phase <= '0;
      for (int s = 0; s < SECTIONS; s++) begin
        z1[s] <= '0;
        z2[s] <= '0;
      end
    end else begin
      if (cmd.osc_step) begin
        phase <= phase + phase_inc;
      end
      if (cmd.act == ACT_Y) begin
        z2[upd] <= z1[upd];
        z1[upd] <= w;
      end
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      sample_out <= res;
    end
  end

endmodule

// ===== hw/rtl/ssb_product_detector.sv =====
// ----------------------------------------------------------------------------
// ssb_product_detector
// Enabled: the single shared multiplier, taking one product per cycle, runs
// the mixer, five products per section and the output scale. Disabled: the
// sample passes straight through. Either way a new item is taken only once
// the last is delivered. Synchronous reset clears phase, delays, enable and
// sets the oscillator to 1500 Hz; the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
module ssb_product_detector #(
  parameter int SINE_ENTRIES = 256,
  parameter int SECTIONS     = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // sample input
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [15:0]         sample_in,
  input  logic                       restart,
  // sample output
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [15:0]         sample_out
);
  import spd_pkg::*;

  localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  logic          enabled;
  logic [31:0]   phase_inc;
  cmd_t          cmd;
  logic [SW-1:0] sec;
  logic [SW-1:0] upd;
  logic          out_free;

  // register accesses never stall
  assign pready = 1'b1;

  // Register file: enable, clamped frequency, and the phase increment derived
  // from the stored frequency through its own register.
  spd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .enabled   (enabled),
    .phase_inc (phase_inc)
  );

  // Sequencer: accept one transfer, then, if enabled, walk the multiplier schedule
  // (mixer, five products per section, output scale) and hand the result
  // to the output register when it is free.
  spd_ctrl #(
    .SECTIONS (SECTIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .enabled  (enabled),
    .out_free (out_free),
    .cmd      (cmd),
    .sec      (sec),
    .upd      (upd)
  );

  // Datapath: oscillator and cosine lookup, shared multiplier with a
  // registered product, accumulator with saturation, biquad delays and
  // the output register that decouples the two channels.
  spd_datapath #(
    .SINE_ENTRIES (SINE_ENTRIES),
    .SECTIONS     (SECTIONS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .restart    (restart),
    .phase_inc  (phase_inc),
    .cmd        (cmd),
    .sec        (sec),
    .upd        (upd),
    .out_free   (out_free),
    .sample_out (sample_out),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

// ===== hw/rtl/spd_checker.sv =====
// ----------------------------------------------------------------------------
// spd_checker
// Port-level assertions for the product detector, bound to the top level.
// ----------------------------------------------------------------------------
module spd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       psel,
  input logic                       pwrite,
  input logic [spd_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                prdata,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [15:0]         sample_out
);

  // one item at a time: ready drops right after a transfer in
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("result changed or dropped while stalled");

  // a new result appears only at the end of an item's work
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in progress");

  // the frequency register reads back inside its clamp range
  a_bfo_range: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite && paddr[2] |-> prdata >= 32'd100 && prdata <= 32'd4000)
    else $error("frequency register out of range");

endmodule

bind ssb_product_detector spd_checker u_spd_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SSB product detector. Samples are sent over the
// valid/ready input, each accepted transfer runs through a bit-true software
// copy of the oscillator, mixer and biquad chain, and every output transfer
// is compared with the oldest predicted sample. The APB registers are written
// and read back between phases while the detector is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int SINE_N    = 256;
  localparam int SECTIONS  = 2;
  localparam int LIMIT     = 400000;  // watchdog, in clock cycles
  localparam int HOLD_LONG = 300;     // long receiver hold-off
  localparam int SHOW_MAX  = 20;      // mismatch lines shown before going quiet

  // register byte addresses
  localparam logic [spd_pkg::ADDR_W-1:0] REG_ENABLED = 3'd0;
  localparam logic [spd_pkg::ADDR_W-1:0] REG_BFO     = 3'd4;

  // biquad coefficient slots
  localparam int SL_B0 = 0;
  localparam int SL_B1 = 1;
  localparam int SL_B2 = 2;
  localparam int SL_A1 = 3;
  localparam int SL_A2 = 4;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [spd_pkg::ADDR_W-1:0] paddr   = '0;
  logic [31:0]                pwdata  = '0;
  logic [31:0]                prdata;
  logic                       pready;

  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic signed [15:0]         sample_in = '0;
  logic                       restart   = 1'b0;

  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [15:0]         sample_out;

  ssb_product_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow of the detector: configuration, oscillator phase, filter delays
  // --------------------------------------------------------------------------
  logic               cfg_enabled;
  logic [11:0]        cfg_bfo;
  logic [31:0]        osc_phase;
  longint             delay_w1 [SECTIONS];
  longint             delay_w2 [SECTIONS];
  logic signed [15:0] sine_tab [SINE_N];
  longint             bq_coef  [2][5];

  logic [15:0] expected_audio [$];

  int errors         = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int config_changes = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_left     = 0;

  task automatic report_mismatch(string what, logic [31:0] exp_val, logic [31:0] got_val);
    errors++;
    if (errors <= SHOW_MAX)
      $display("[%0t] mismatch: %s expected 0x%0h got 0x%0h", $realtime, what, exp_val,
               got_val);
  endtask

  // First-quadrant Taylor series in Q2.30, folded out to a full sine period.
  function automatic logic signed [15:0] sine_value(int k);
    logic [63:0] m, a, a2, term;
    longint      acc, q;
    bit          neg;
    m   = 64'(4 * (k % SINE_N));
    neg = 1'b0;
    if (m >= 64'(2 * SINE_N)) begin
      neg = 1'b1;
      m   = m - 64'(2 * SINE_N);
    end
    if (m > 64'(SINE_N)) m = 64'(2 * SINE_N) - m;
    a    = HALF_PI_Q30 * m / 64'(SINE_N);
    a2   = (a * a) >> 30;
    term = a;
    acc  = longint'(a);
    for (int i = 1; i <= 7; i++) begin
      term = ((term * a2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    q = (acc + 64'sd16384) >>> 15;
    if (q > 32767) q = 32767;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void clear_run();
    osc_phase = '0;
    for (int s = 0; s < SECTIONS; s++) begin
      delay_w1[s] = 0;
      delay_w2[s] = 0;
    end
  endfunction

  function automatic void shadow_reset();
    cfg_enabled = 1'b0;
    cfg_bfo     = 12'd1500;
    clear_run();
    for (int k = 0; k < SINE_N; k++) sine_tab[k] = sine_value(k);
    bq_coef[0] = '{413270, 826539, 413270, -3954428, 1398101};
    bq_coef[1] = '{4194304, 8388608, 4194304, -1123860, 719629};
  endfunction

  // Advance the shadow by one accepted sample and return the sample it yields.
  function automatic logic [15:0] predict_sample(logic [15:0] raw, logic clr);
    logic [63:0] step, idx;
    longint      x, w, y, z1v, z2v, q;
    int          sel, cidx;
    if (clr) clear_run();
    if (!cfg_enabled) return raw;
    step      = (64'(cfg_bfo) << 32) / 64'd16000;
    idx       = (64'(osc_phase) * 64'(SINE_N)) >> 32;
    cidx      = int'((idx + 64'(SINE_N / 4)) % 64'(SINE_N));
    osc_phase = osc_phase + step[31:0];
    x = (longint'($signed(raw)) * longint'(sine_tab[cidx])) >>> 4;
    for (int s = 0; s < SECTIONS; s++) begin
      sel = s % 2;
      z1v = delay_w1[s];
      z2v = delay_w2[s];
      w = clamp32(x - ((bq_coef[sel][SL_A1] * z1v) >>> 22)
                    - ((bq_coef[sel][SL_A2] * z2v) >>> 22));
      y = clamp32(((bq_coef[sel][SL_B0] * w) >>> 22) + ((bq_coef[sel][SL_B1] * z1v) >>> 22)
                  + ((bq_coef[sel][SL_B2] * z2v) >>> 22));
      delay_w2[s] = delay_w1[s];
      delay_w1[s] = w;
      x = y;
    end
    q = (x * 64'sd65534) / 64'sd67108864;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a counted hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every output transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_audio.size() == 0) begin
        report_mismatch("unexpected output transfer", 32'h0, 32'(sample_out));
      end else begin
        if (sample_out !== expected_audio[0])
          report_mismatch("sample_out", 32'(expected_audio[0]), 32'(sample_out));
        void'(expected_audio.pop_front());
        results_seen++;
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("watchdog expired with %0d samples outstanding", expected_audio.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. Each one is entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // Offer one sample, hold it until the transfer, then predict its output.
  // Valid stays high on return so back-to-back transfers never glitch it.
  task automatic send_sample(logic [15:0] value, logic clr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= value;
    restart   <= clr;
    do @(posedge clk); while (!in_ready);
    expected_audio.push_back(predict_sample(value, clr));
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted sample has been transferred out,
  // then let the pipeline settle.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_audio.size() != 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(logic [spd_pkg::ADDR_W-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_ENABLED) begin
      cfg_enabled = data[0];
    end else if (addr == REG_BFO) begin
      if (data[11:0] < 12'd100) cfg_bfo = 12'd100;
      else if (data[11:0] > 12'd4000) cfg_bfo = 12'd4000;
      else cfg_bfo = data[11:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(logic [spd_pkg::ADDR_W-1:0] addr, logic [31:0] exp_val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== exp_val) report_mismatch("register readback", exp_val, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reconfigure only from idle; read both registers back after the writes.
  task automatic set_config(logic [31:0] en_word, logic [31:0] bfo_word);
    wait_drain();
    apb_write(REG_ENABLED, en_word);
    apb_write(REG_BFO, bfo_word);
    apb_read_check(REG_ENABLED, {31'b0, cfg_enabled});
    apb_read_check(REG_BFO, {20'b0, cfg_bfo});
    config_changes++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Disabled after reset: samples pass through, restart still clears state.
  task automatic test_passthrough();
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h5555, 1'b1);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h0001, 1'b0);
  endtask

  // Enabled with the oscillator clamped at both ends, full-scale inputs and
  // restarts in mid-stream.
  task automatic test_demod_directed();
    set_config(32'd1, 32'd0);                 // clamps up to 100 Hz
    send_sample(16'h7FFF, 1'b1);
    repeat (4) send_sample(16'h7FFF, 1'b0);
    set_config(32'd1, 32'd4095);              // clamps down to 4000 Hz
    repeat (5) send_sample(16'h8000, 1'b0);
    set_config(32'hFFFF_FFFF, 32'hFFFF_F063); // upper bits ignored, 99 clamps to 100
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    set_config(32'd1, 32'd4001);
    send_sample(16'h4000, 1'b0);
    send_sample(16'hC000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
  endtask

  task automatic pick_random_config();
    logic [31:0] en_word, bfo_word;
    int          pick;
    en_word    = $urandom;
    en_word[0] = ($urandom_range(9) != 0);
    pick = $urandom_range(99);
    if (pick < 25) begin
      bfo_word = $urandom_range(150);
    end else if (pick < 40) begin
      case ($urandom_range(5))
        0: bfo_word = 32'd0;
        1: bfo_word = 32'd99;
        2: bfo_word = 32'd100;
        3: bfo_word = 32'd4000;
        4: bfo_word = 32'd4001;
        default: bfo_word = 32'd4095;
      endcase
    end else begin
      bfo_word = $urandom_range(4095);
    end
    if ($urandom_range(3) == 0) bfo_word[31:12] = 20'($urandom);
    set_config(en_word, bfo_word);
  endtask

  // Mostly clean audio-like streams: random, held (DC) runs that drive the
  // filter into saturation, small signals and full-scale values; rare restarts.
  task automatic run_random_segment(int count);
    logic [15:0] value;
    logic        clr;
    int          kind;
    value = '0;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        value = 16'($urandom);
      end else if (kind < 70) begin
        // hold the previous sample
      end else if (kind < 85) begin
        value = 16'($urandom_range(2047)) - 16'd1024;
      end else begin
        case ($urandom_range(3))
          0: value = 16'h8000;
          1: value = 16'h7FFF;
          2: value = 16'hFFFF;
          default: value = 16'h0000;
        endcase
      end
      clr = ($urandom_range(99) < 3);
      if ($urandom_range(199) == 0) wait_drain();
      send_sample(value, clr);
    end
  endtask

  task automatic test_random_traffic(int sidle, int ridle, int segments, int per_seg);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int g = 0; g < segments; g++) begin
      pick_random_config();
      run_random_segment(per_seg);
    end
  endtask

  // Hold the receiver off for a long stretch while samples keep coming so the
  // detector fills and stalls its input, then pause the sender until drained.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(32'd1, 32'd1200);
    hold_req = HOLD_LONG;
    run_random_segment(40);
    wait_drain();
    run_random_segment(10);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    shadow_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 6;
    recv_idle_pct = 88;
    test_passthrough();
    test_demod_directed();
    test_random_traffic(6, 88, 4, 130);
    test_random_traffic(88, 6, 4, 130);
    test_backpressure();
    test_random_traffic(0, 0, 4, 130);

    // Drain with a bound, then settle past the pipeline latency.
    in_valid <= 1'b0;
    for (int c = 0; c < 5000 && expected_audio.size() != 0; c++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_audio.size() != 0)
      report_mismatch("samples never transferred out", 32'h0, 32'(expected_audio.size()));

    $display("covered %0d samples and %0d checked outputs over %0d register settings",
             items_sent, results_seen, config_changes);
    $display("idling sender/receiver 6/88, 88/6, none; one %0d-cycle receiver hold-off",
             HOLD_LONG);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
